// File: rtl/request_retry_backoff_controller_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the retry/backoff controller rtl
// ----------------------------------------------------------------------------
`ifndef REQUEST_RETRY_BACKOFF_CONTROLLER_CORE_MACROS_SVH
`define REQUEST_RETRY_BACKOFF_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrb assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrb assertion failed");

`endif

// File: rtl/rrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_pkg
// types and constants of the request retry / backoff controller
// ----------------------------------------------------------------------------
package rrb_pkg;

    // event codes
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_DATA    = 3'd1,
        OP_NACK    = 3'd2,
        OP_TIMEOUT = 3'd3,
        OP_STOP    = 3'd4,
        OP_EXPIRE  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_SEND  = 3'd1,
        ACT_DELAY = 3'd2,
        ACT_OK    = 3'd3,
        ACT_FAIL  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_CANCELLED   = 2'd1,
        ST_UNREACHABLE = 2'd2,
        ST_TIMEDOUT    = 2'd3
    } t_status;

    // nack reasons
    localparam logic [1:0] REASON_DUPLICATE  = 2'd0;
    localparam logic [1:0] REASON_CONGESTION = 2'd1;

    // register indexes
    localparam logic [1:0] CFG_MAX_NACK    = 2'd0;
    localparam logic [1:0] CFG_MAX_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_BACKOFF = 2'd2;

    // register reset values
    localparam logic [7:0]  RST_MAX_NACK    = 8'd16;
    localparam logic [7:0]  RST_MAX_TIMEOUT = 8'd32;
    localparam logic [15:0] RST_MAX_BACKOFF = 16'd8000;

    // any exponent at or above this gives 2^exp beyond a 16-bit cap
    localparam logic [4:0] EXP_SAT = 5'd16;

    typedef struct packed {
        logic [7:0]  max_nack;
        logic [7:0]  max_timeout;
        logic [15:0] max_backoff;
    } t_cfg;

    typedef struct packed {
        logic [7:0] nack_count;
        logic [7:0] timeout_count;
        logic [4:0] exponent;
        logic       stopped;
        logic       failed;
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] delay_ms;
        t_status     status;
    } t_result;

endpackage

// File: rtl/rrb_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_engine
// decision logic: one event against the current state gives the next state
// and one result
// ----------------------------------------------------------------------------
module rrb_engine
    import rrb_pkg::*;
(
    input  t_op        i_op,
    input  logic [1:0] i_reason,
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    output t_state     o_state,
    output t_result    o_result
);

    logic        exp_sat;
    logic [15:0] pow_ms;
    logic        over_cap;
    logic [15:0] wait_ms;

    assign exp_sat  = (i_state.exponent >= EXP_SAT);
    assign pow_ms   = 16'd1 << i_state.exponent[3:0];
    assign over_cap = exp_sat || (pow_ms > i_cfg.max_backoff);
    assign wait_ms  = over_cap ? i_cfg.max_backoff : pow_ms;

    always_comb begin
        o_state  = i_state;
        o_result = '{action: ACT_NONE, delay_ms: 16'd0, status: ST_OK};
        if (!i_state.stopped && !i_state.failed) begin
            case (i_op)
                OP_START, OP_EXPIRE: begin
                    o_state.exponent = '0;
                    o_result.action  = ACT_SEND;
                end
                OP_DATA: begin
                    o_state.stopped = 1'b1;
                    o_result.action = ACT_OK;
                end
                OP_NACK: begin
                    if (i_state.nack_count >= i_cfg.max_nack) begin
                        o_state.failed  = 1'b1;
                        o_result.action = ACT_FAIL;
                        o_result.status = ST_UNREACHABLE;
                    end else begin
                        o_state.nack_count = i_state.nack_count + 8'd1;
                        case (i_reason)
                            REASON_DUPLICATE: begin
                                o_state.exponent = '0;
                                o_result.action  = ACT_SEND;
                            end
                            REASON_CONGESTION: begin
                                // exponent only grows while 2^exp does not exceed the cap
                                if (!over_cap) begin
                                    o_state.exponent = i_state.exponent + 5'd1;
                                end
                                o_result.action   = ACT_DELAY;
                                o_result.delay_ms = wait_ms;
                            end
                            default: begin
                                o_state.failed  = 1'b1;
                                o_result.action = ACT_FAIL;
                                o_result.status = ST_UNREACHABLE;
                            end
                        endcase
                    end
                end
                OP_TIMEOUT: begin
                    if (i_state.timeout_count >= i_cfg.max_timeout) begin
                        o_state.failed  = 1'b1;
                        o_result.action = ACT_FAIL;
                        o_result.status = ST_TIMEDOUT;
                    end else begin
                        o_state.timeout_count = i_state.timeout_count + 8'd1;
                        o_state.exponent      = '0;
                        o_result.action       = ACT_SEND;
                    end
                end
                OP_STOP: begin
                    o_state.stopped = 1'b1;
                    o_result.action = ACT_FAIL;
                    o_result.status = ST_CANCELLED;
                end
                default: begin
                    // undefined event codes are ignored
                end
            endcase
        end
    end

endmodule

// File: rtl/request_retry_backoff_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_retry_backoff_controller_core
// retry controller for one outstanding request with capped exponential backoff
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (i_op, i_nack_reason) with i_in_valid;
//   a beat is taken at a clock edge where o_in_stall is low. Each event gives
//   exactly one result beat (o_action, o_delay_ms, o_status) on the output
//   channel, taken where o_out_valid is high and i_out_stall is low.
//   An accepted event waits in the input register until the result register
//   can be loaded; the combinational decision logic between the two registers
//   updates the counters. One event per cycle unless the receiver stalls.
//   When the receiver stalls the result register holds, the input register
//   fills, and o_in_stall rises; nothing is dropped.
//   Limits are written on the configuration channel (i_cfg_index, i_cfg_data),
//   always ready; index 0 nack limit, 1 timeout limit, 2 backoff cap in ms,
//   other indexes are ignored. Write only while no event is in flight.
//   Synchronous reset clears all counters and flags, empties both registers
//   and loads the limits with 16, 32 and 8000 ms.
// ----------------------------------------------------------------------------
`include "request_retry_backoff_controller_core_macros.svh"

module request_retry_backoff_controller_core
    import rrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [1:0]  i_nack_reason,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [15:0] o_delay_ms,
    output logic [1:0]  o_status,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic       r_in_valid;
    t_op        r_in_op;
    logic [1:0] r_in_reason;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    t_cfg       r_cfg;

    t_state     n_state;
    t_result    n_out;

    logic advance;
    logic fire;
    logic in_take;

    // result register can be loaded when empty or being drained this cycle
    assign advance = !r_out_valid || !i_out_stall;
    assign fire    = r_in_valid && advance;
    assign in_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    rrb_engine u_engine (
        .i_op     (r_in_op),
        .i_reason (r_in_reason),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_cfg       <= '{max_nack:    RST_MAX_NACK,
                             max_timeout: RST_MAX_TIMEOUT,
                             max_backoff: RST_MAX_BACKOFF};
        end else begin
            // input register fills even while the result register is held
            r_in_valid <= in_take || (r_in_valid && !fire);
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_NACK:    r_cfg.max_nack    <= i_cfg_data[7:0];
                    CFG_MAX_TIMEOUT: r_cfg.max_timeout <= i_cfg_data[7:0];
                    CFG_MAX_BACKOFF: r_cfg.max_backoff <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op     <= t_op'(i_op);
            r_in_reason <= i_nack_reason;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_out.action;
    assign o_delay_ms  = r_out.delay_ms;
    assign o_status    = r_out.status;

    // terminal flags are sticky
    `RRB_ASSERT_NXT(a_stopped_sticky, i_clk, i_rst_n, r_state.stopped, r_state.stopped)
    `RRB_ASSERT_NXT(a_failed_sticky, i_clk, i_rst_n, r_state.failed, r_state.failed)
    // exponent stops once 2^exp exceeds any 16-bit cap
    `RRB_ASSERT_IMP(a_exp_bound, i_clk, i_rst_n, 1'b1, r_state.exponent <= EXP_SAT)
    // only a delayed send carries a delay, and never beyond the cap
    `RRB_ASSERT_IMP(a_delay_only, i_clk, i_rst_n,
                    r_out_valid && (r_out.delay_ms != 16'd0), r_out.action == ACT_DELAY)
    `RRB_ASSERT_IMP(a_delay_cap, i_clk, i_rst_n,
                    r_out_valid && (r_out.action == ACT_DELAY),
                    r_out.delay_ms <= r_cfg.max_backoff)

endmodule
